// ----- rtl/core/mtfm_pkg.sv -----
// Shared types and constants for the topic filter matcher.
`timescale 1ns / 1ps
package mtfm_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int PATTERN_LEN_DEF = 64;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 3;
  localparam int CHAR_W = 8;
  localparam int MASK_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_SEP  = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;
  localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TOPIC  = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_PLUS    = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  // One request as it travels down the row of slot cells.
  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [CHAR_W-1:0] char_byte;
    logic              level_open;
    logic [MASK_W-1:0] mask;
  } item_t;

endpackage

// ----- rtl/core/mtfm_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module mtfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- rtl/core/mtfm_cell.sv -----
// One subscription slot: pattern RAM, match progress and a pipeline stage.
`timescale 1ns / 1ps
module mtfm_cell #(
  parameter int IDX         = 0,
  parameter int PATTERN_LEN = mtfm_pkg::PATTERN_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtfm_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output mtfm_pkg::item_t out_item
);
  import mtfm_pkg::*;

  localparam int LEN_W  = $clog2(PATTERN_LEN + 1);
  localparam int ADDR_W = $clog2(PATTERN_LEN);
  localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(PATTERN_LEN);
  localparam logic [LEN_W-1:0]  ONE     = LEN_W'(1);
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic              slot_valid, slot_valid_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  pos, pos_next, pos_next_p1;
  mode_t             mode, mode_next;
  logic [CHAR_W-1:0] ram_a, ram_b, byp_data;
  logic [CHAR_W-1:0] w0, w1;
  logic              byp0, byp1;
  logic              xfer, wr_en;
  item_t             item_next;

  assign in_ready = !out_valid || out_ready;
  assign xfer     = in_valid && in_ready;

  // w0/w1 hold pattern bytes at pos and pos+1; a same-cycle write is forwarded
  assign w0 = byp0 ? byp_data : ram_a;
  assign w1 = byp1 ? byp_data : ram_b;

  always_comb begin
    mode_t             m;
    logic [LEN_W-1:0]  p;
    logic              sel1;
    logic              last;
    logic              verdict;
    logic              hit;
    logic [CHAR_W-1:0] pq;
    logic [CHAR_W-1:0] pf;

    m       = mode;
    p       = pos;
    sel1    = 1'b0;
    last    = (pos + ONE == len);
    verdict = 1'b0;
    hit     = (in_item.slot == MY_SLOT);
    pq      = w0;
    pf      = w0;
    len_next        = len;
    slot_valid_next = slot_valid;
    wr_en           = 1'b0;

    case (in_item.cmd)
      CMD_CLEAR: begin
        if (hit) begin
          len_next        = '0;
          slot_valid_next = 1'b1;
          p               = '0;
          m               = MODE_START;
        end
      end
      CMD_APPEND: begin
        if (hit && slot_valid) begin
          if (len >= LEN_MAX) begin
            slot_valid_next = 1'b0;
          end else begin
            wr_en    = 1'b1;
            len_next = len + ONE;
          end
        end
      end
      CMD_TOPIC: begin
        // first byte of a topic level
        if (!in_item.level_open && m == MODE_START) begin
          if (p >= len) begin
            m = MODE_DONE;
            p = '0;
          end else if (w0 == CHAR_HASH && (last || w1 == CHAR_SEP)) begin
            m = MODE_DONE;
            p = LEN_W'(last);
          end else if (w0 == CHAR_PLUS && (last || w1 == CHAR_SEP)) begin
            m    = MODE_PLUS;
            p    = pos + ONE;
            sel1 = 1'b1;
          end else begin
            m = MODE_LITERAL;
          end
        end
        pq = sel1 ? w1 : w0;
        if (in_item.char_byte == CHAR_SEP) begin
          if (m == MODE_LITERAL || m == MODE_PLUS) begin
            if (p >= len) begin
              p = len;
              m = MODE_START;
            end else if (pq == CHAR_SEP) begin
              p = p + ONE;
              m = MODE_START;
            end else begin
              m = MODE_DONE;
              p = '0;
            end
          end
        end else if (m == MODE_LITERAL) begin
          if (p < len && pq == in_item.char_byte) begin
            p = p + ONE;
          end else begin
            m = MODE_DONE;
            p = '0;
          end
        end
      end
      CMD_END: begin
        if (in_item.level_open && (m == MODE_LITERAL || m == MODE_PLUS)) begin
          if (p >= len) begin
            p = len;
            m = MODE_START;
          end else if (w0 == CHAR_SEP) begin
            p  = p + ONE;
            m  = MODE_START;
            pf = w1;
          end else begin
            m = MODE_DONE;
            p = '0;
          end
        end
        case (m)
          MODE_DONE:  verdict = p[0];
          MODE_START: verdict = (p == len) || ((p + ONE == len) && pf == CHAR_HASH);
          default:    verdict = 1'b0;
        endcase
        p = '0;
        m = MODE_START;
      end
      default: ;
    endcase

    item_next = in_item;
    if (in_item.cmd == CMD_END && slot_valid && verdict) begin
      item_next.mask[IDX] = 1'b1;
    end

    mode_next = xfer ? m : mode;
    pos_next  = xfer ? p : pos;
    if (!xfer) begin
      len_next        = len;
      slot_valid_next = slot_valid;
      wr_en           = 1'b0;
    end
  end

  assign pos_next_p1 = pos_next + ONE;

  mtfm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (PATTERN_LEN)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (len[ADDR_W-1:0]),
    .wr_data   (in_item.char_byte),
    .rd_addr_a (pos_next[ADDR_W-1:0]),
    .rd_data_a (ram_a),
    .rd_addr_b (pos_next_p1[ADDR_W-1:0]),
    .rd_data_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      slot_valid <= 1'b0;
      len        <= '0;
      pos        <= '0;
      mode       <= MODE_START;
      byp0       <= 1'b0;
      byp1       <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      slot_valid <= slot_valid_next;
      len        <= len_next;
      pos        <= pos_next;
      mode       <= mode_next;
      byp0       <= wr_en && (len == pos_next);
      byp1       <= wr_en && (len == pos_next_p1);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= in_item.char_byte;
    if (xfer) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- rtl/core/mqtt_topic_filter_matcher.sv -----
// Top level of the topic filter matcher: row of slot cells and result register.
`timescale 1ns / 1ps
// Each request (clear slot, append pattern byte, topic byte, topic end) enters a row of
// SLOTS identical cells, one per subscription slot, and moves one cell per cycle unless
// the row stalls. Every cell updates its own slot's pattern and match progress as the
// request passes and, for a matching topic end, sets its bit in the travelling mask.
// One request is taken every cycle while the row does not stall; a topic end's result,
// match_mask / any_match, is registered once it has left the last cell. The rate is set
// by each cell's progress update, which reads the pattern byte at its position and the next
// from its two-read-port pattern RAM in the same cycle. The row buffers SLOTS requests, so
// input keeps flowing while a result waits, until the next topic end reaches the row's end.
module mqtt_topic_filter_matcher #(
  parameter int SLOTS       = mtfm_pkg::SLOTS_DEF,
  parameter int PATTERN_LEN = mtfm_pkg::PATTERN_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mtfm_pkg::CMD_W-1:0]  command,
  input  logic [mtfm_pkg::SLOT_W-1:0] slot,
  input  logic [mtfm_pkg::CHAR_W-1:0] char_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtfm_pkg::MASK_W-1:0] match_mask,
  output logic                        any_match
);
  import mtfm_pkg::*;

  item_t chain_item  [SLOTS+1];
  logic  chain_valid [SLOTS+1];
  logic  chain_ready [SLOTS+1];
  logic  level_open;
  logic  accept;
  logic  last_is_end;
  logic  take_end;

  assign accept   = in_valid && in_ready;
  assign in_ready = chain_ready[0];

  assign chain_valid[0]           = in_valid;
  assign chain_item[0].cmd        = cmd_t'(command);
  assign chain_item[0].slot       = slot;
  assign chain_item[0].char_byte  = char_byte;
  assign chain_item[0].level_open = level_open;
  assign chain_item[0].mask       = '0;

  // level_open: a byte of the current topic level has been seen
  always_ff @(posedge clk) begin
    if (rst) begin
      level_open <= 1'b0;
    end else if (accept) begin
      case (cmd_t'(command))
        CMD_TOPIC: level_open <= (char_byte != CHAR_SEP);
        CMD_END:   level_open <= 1'b0;
        default:   level_open <= level_open;
      endcase
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mtfm_cell #(
      .IDX         (i),
      .PATTERN_LEN (PATTERN_LEN)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  // non-end requests drop off the end of the row
  assign last_is_end        = (chain_item[SLOTS].cmd == CMD_END);
  assign chain_ready[SLOTS] = !last_is_end || !out_valid || out_ready;
  assign take_end           = chain_valid[SLOTS] && chain_ready[SLOTS] && last_is_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      match_mask <= chain_item[SLOTS].mask;
      any_match  <= |chain_item[SLOTS].mask;
    end
  end

  a_any_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_match == (match_mask != '0)))
    else $error("any_match disagrees with match_mask");

  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((match_mask >> SLOTS) == '0))
    else $error("match bit set for a slot that does not exist");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd_t'(command) == CMD_END) |=> !level_open)
    else $error("topic level still open after topic end");

endmodule
